/* hw/rtl/cbt_pkg.sv */
package cbt_pkg;

	localparam int MAX_DEPTH_LIMIT = 12;
	localparam int HEAP_WORDS      = 1024;
	localparam int ADDR_W          = $clog2(HEAP_WORDS);

	localparam logic [2:0] FUNC_CLEAR  = 3'd0;
	localparam logic [2:0] FUNC_SETBIT = 3'd1;
	localparam logic [2:0] FUNC_WRITE  = 3'd2;
	localparam logic [2:0] FUNC_READ   = 3'd3;
	localparam logic [2:0] FUNC_REDUCE = 3'd4;

	typedef struct packed {
		logic [2:0]  func;
		logic [12:0] node_id;
		logic [3:0]  depth;
		logic [12:0] value;
	} cbt_in_t;

	typedef struct packed {
		logic [12:0] read_data;
		logic        status;
	} cbt_out_t;

	// classified command handed from front to back
	typedef struct packed {
		logic [2:0]  func;
		logic        bad;
		logic [12:0] node_id;
		logic [3:0]  depth;
		logic [3:0]  md;
		logic [12:0] value;
	} cbt_cmd_t;

endpackage

/* hw/rtl/cbt_front.sv */
module cbt_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  cbt_pkg::cbt_in_t in_data,
	input  logic             cfg_we,
	input  logic [3:0]       cfg_wdata,
	output logic             cmd_valid,
	input  logic             cmd_ready,
	output cbt_pkg::cbt_cmd_t cmd
);
	import cbt_pkg::*;

	logic [3:0] max_depth_q;
	logic [3:0] md;
	logic       cmd_valid_q;
	cbt_cmd_t   cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_depth_q <= 4'd12;
		end else if (cfg_we) begin
			max_depth_q <= cfg_wdata;
		end
	end

	assign md = (max_depth_q > 4'(MAX_DEPTH_LIMIT)) ? 4'(MAX_DEPTH_LIMIT) : max_depth_q;
	assign full = cmd_valid_q && !cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else if (!full) begin
			cmd_valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (!full && push) begin
			cmd_q.func    <= in_data.func;
			cmd_q.bad     <= (in_data.func != FUNC_CLEAR) && (in_data.func <= FUNC_REDUCE)
			                 && (in_data.depth > md);
			cmd_q.node_id <= in_data.node_id;
			cmd_q.depth   <= in_data.depth;
			cmd_q.md      <= md;
			cmd_q.value   <= in_data.value;
		end
	end

	assign cmd_valid = cmd_valid_q;
	assign cmd       = cmd_q;
endmodule

/* hw/rtl/cbt_back.sv */
module cbt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  cbt_pkg::cbt_cmd_t cmd,
	output logic              empty,
	input  logic              pop,
	output cbt_pkg::cbt_out_t out_data
);
	import cbt_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_CLR    = 4'd1;
	localparam logic [3:0] ST_RD0    = 4'd2;
	localparam logic [3:0] ST_RD1    = 4'd3;
	localparam logic [3:0] ST_MOD    = 4'd4;
	localparam logic [3:0] ST_WR0    = 4'd5;
	localparam logic [3:0] ST_WR1    = 4'd6;
	localparam logic [3:0] ST_DONE   = 4'd7;
	localparam logic [3:0] ST_RINIT  = 4'd8;
	localparam logic [3:0] ST_RBRD   = 4'd9;
	localparam logic [3:0] ST_INIT   = 4'd10;

	// ops for one read-modify-write
	localparam logic [1:0] OP_FIELD_RD = 2'd0;
	localparam logic [1:0] OP_FIELD_WR = 2'd1;
	localparam logic [1:0] OP_BIT      = 2'd2;

	logic [31:0] mem [HEAP_WORDS];
	logic [31:0] rdata_q;

	logic [3:0]  state_q;
	cbt_cmd_t    c_q;
	logic [1:0]  op_q;
	logic        rd_is_a_q;     // reduce: reading child a (else b)
	logic        red_q;         // current access belongs to a reduce
	logic [ADDR_W:0] clr_q;
	logic        init_q;        // clearing pass after reset

	logic [31:0] off_q;         // bit offset of the access
	logic [4:0]  nbits_q;
	logic [31:0] wval_q;
	logic [31:0] w0_q, w1_q;
	logic [12:0] suma_q;
	logic [3:0]  lvl_q;
	logic [12:0] n_q;

	cbt_out_t    res_q;         // result being built
	logic        out_valid_q;
	cbt_out_t    out_q;

	logic [31:0] idx;
	logic        in0, in1;
	logic [ADDR_W-1:0] a0, a1;
	logic [63:0] both, m64, nb;
	logic [4:0]  w_child;

	assign idx = off_q >> 5;
	assign in0 = idx < 32'(HEAP_WORDS);
	assign in1 = (idx + 32'd1) < 32'(HEAP_WORDS);
	assign a0  = idx[ADDR_W-1:0];
	assign a1  = ADDR_W'(idx + 32'd1);
	assign both = {in1 ? w1_q : 32'd0, w0_q};
	assign m64  = (64'(({32'd0, 32'hFFFF_FFFF} >> (6'd32 - 6'(nbits_q)))) << off_q[4:0]);
	assign nb   = (both & ~m64) | ((64'(wval_q) << off_q[4:0]) & m64);

	assign cmd_ready = (state_q == ST_IDLE) && !init_q;
	assign empty = !out_valid_q;
	assign out_data = out_q;

	// offset = (2<<md) + id*(md-d+1)
	function automatic logic [31:0] node_off(logic [12:0] id, logic [3:0] d, logic [3:0] md);
		logic [4:0] w;
		w = 5'(md) - 5'(d) + 5'd1;
		return (32'd2 << md) + 32'(id) * 32'(w);
	endfunction

	assign w_child = 5'(c_q.md) - 5'(lvl_q) + 5'd1;

	always_ff @(posedge clk) begin
		rdata_q <= mem[(state_q == ST_RD1 || state_q == ST_RBRD) ? a1 : a0];
		if (state_q == ST_CLR || state_q == ST_INIT) begin
			mem[clr_q[ADDR_W-1:0]] <= (clr_q == '0 && state_q == ST_CLR)
			                          ? (32'd1 << c_q.md) : 32'd0;
		end else if (state_q == ST_WR0 && in0) begin
			mem[a0] <= nb[31:0];
		end else if (state_q == ST_WR1 && in1) begin
			mem[a1] <= nb[63:32];
		end
	end

	// hold the result until popped; a finished request moves in as the old one leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (state_q == ST_DONE && (!out_valid_q || pop)) begin
			out_valid_q <= 1'b1;
			out_q       <= res_q;
		end else if (pop && out_valid_q) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			init_q      <= 1'b1;
			clr_q       <= '0;
			red_q       <= 1'b0;
			rd_is_a_q   <= 1'b0;
			c_q         <= '0;
			op_q        <= OP_FIELD_RD;
			off_q       <= '0;
			nbits_q     <= '0;
			wval_q      <= '0;
			w0_q        <= '0;
			w1_q        <= '0;
			suma_q      <= '0;
			lvl_q       <= '0;
			n_q         <= '0;
			res_q       <= '0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (ADDR_W+1)'(HEAP_WORDS - 1)) begin
						init_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						c_q             <= cmd;
						red_q           <= 1'b0;
						res_q.read_data <= '0;
						res_q.status    <= cmd.bad;
						if (cmd.bad) begin
							state_q <= ST_DONE;
						end else begin
							unique case (cmd.func)
								FUNC_CLEAR: begin
									clr_q   <= '0;
									state_q <= ST_CLR;
								end
								FUNC_SETBIT: begin
									op_q    <= OP_BIT;
									off_q   <= (32'd2 << cmd.md)
									           + (32'(cmd.node_id) << (cmd.md - cmd.depth));
									nbits_q <= 5'd1;
									wval_q  <= 32'd1;
									state_q <= ST_RD0;
								end
								FUNC_WRITE: begin
									op_q    <= OP_FIELD_WR;
									off_q   <= node_off(cmd.node_id, cmd.depth, cmd.md);
									nbits_q <= 5'(cmd.md) - 5'(cmd.depth) + 5'd1;
									wval_q  <= 32'(cmd.value);
									state_q <= ST_RD0;
								end
								FUNC_READ: begin
									op_q    <= OP_FIELD_RD;
									off_q   <= node_off(cmd.node_id, cmd.depth, cmd.md);
									nbits_q <= 5'(cmd.md) - 5'(cmd.depth) + 5'd1;
									state_q <= ST_RD0;
								end
								FUNC_REDUCE: begin
									lvl_q   <= cmd.depth;
									state_q <= ST_RINIT;
								end
								default: state_q <= ST_DONE;
							endcase
						end
					end
				end
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (ADDR_W+1)'(HEAP_WORDS - 1)) state_q <= ST_DONE;
				end
				ST_RINIT: begin
					// start the next level, or finish at the root
					if (lvl_q == 4'd0) begin
						state_q <= ST_DONE;
					end else begin
						n_q       <= 13'd1 << (lvl_q - 4'd1);
						red_q     <= 1'b1;
						rd_is_a_q <= 1'b1;
						op_q      <= OP_FIELD_RD;
						off_q     <= node_off(13'(1) << lvl_q, lvl_q, c_q.md);
						nbits_q   <= 5'(c_q.md) - 5'(lvl_q) + 5'd1;
						state_q   <= ST_RD0;
					end
				end
				ST_RD0: state_q <= ST_RD1;
				ST_RD1: begin
					w0_q    <= in0 ? rdata_q : 32'd0;
					state_q <= ST_RBRD;
				end
				ST_RBRD: begin
					w1_q    <= rdata_q;
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					if (op_q == OP_FIELD_RD) begin
						if (red_q) begin
							if (rd_is_a_q) begin
								suma_q    <= 13'(32'(both >> off_q[4:0]) &
								             (32'hFFFF_FFFF >> (6'd32 - 6'(nbits_q))));
								rd_is_a_q <= 1'b0;
								off_q     <= off_q + 32'(w_child);
								state_q   <= ST_RD0;
							end else begin
								// write parent = a + b, masked to parent width
								op_q    <= OP_FIELD_WR;
								wval_q  <= 32'(suma_q) + (32'(both >> off_q[4:0]) &
								           (32'hFFFF_FFFF >> (6'd32 - 6'(nbits_q))));
								nbits_q <= w_child + 5'd1;
								off_q   <= node_off(n_q, lvl_q - 4'd1, c_q.md);
								state_q <= ST_RD0;
							end
						end else begin
							res_q.read_data <= 13'(32'(both >> off_q[4:0]) &
							                   (32'hFFFF_FFFF >> (6'd32 - 6'(nbits_q))));
							state_q <= ST_DONE;
						end
					end else begin
						state_q <= ST_WR0;
					end
				end
				ST_WR0: state_q <= ST_WR1;
				ST_WR1: begin
					if (red_q) begin
						// advance to next parent or next level
						if (n_q == ((13'd2 << (lvl_q - 4'd1)) - 13'd1)) begin
							lvl_q   <= lvl_q - 4'd1;
							state_q <= ST_RINIT;
						end else begin
							n_q       <= n_q + 13'd1;
							rd_is_a_q <= 1'b1;
							op_q      <= OP_FIELD_RD;
							nbits_q   <= w_child;
							off_q     <= node_off(13'((n_q + 13'd1) << 1), lvl_q, c_q.md);
							state_q   <= ST_RD0;
						end
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || pop) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* hw/rtl/cbt_packed_sum_tree_engine_top.sv */
// Packed concurrent-binary-tree engine: commands enter through a push/full queue
// port and each returns one result (read_data, status) through an empty/pop port.
// A front stage registers and classifies the request; a back sequencer performs
// it on a 1024 x 32 store and parks the result in an output register,
// so the next request can start while a result waits to be popped. The back
// takes a new request only once the last is finished; set-bit and write do a
// two-word read-modify-write. Clear rewrites every word; reduce from leaf
// depth d writes each of its 2^d - 1 parent nodes, one level at a time. After
// reset the store is zeroed in one pass over all 1024 words before requests
// are taken.
module cbt_packed_sum_tree_engine_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  cbt_pkg::cbt_in_t  in_data,
	output logic              empty,
	input  logic              pop,
	output cbt_pkg::cbt_out_t out_data,
	input  logic              cfg_we,
	input  logic [3:0]        cfg_wdata
);
	import cbt_pkg::*;

	logic     cmd_valid, cmd_ready;
	cbt_cmd_t cmd;

	cbt_front u_front (
		.clk, .arst_n, .push, .full, .in_data, .cfg_we, .cfg_wdata,
		.cmd_valid, .cmd_ready, .cmd
	);

	cbt_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd, .empty, .pop, .out_data
	);
endmodule
